// File: rtl/swfr_pkg.sv
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared widths, constants and controller/datapath handshake types for the
// sliding window frame rate unit.
// ----------------------------------------------------------------------------
package swfr_pkg;

  localparam int unsigned TICK_W   = 32;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned RATE_W   = 20;
  localparam int unsigned FRAMES_W = 11;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
  localparam int unsigned         MS_PER_SEC   = 1000;
  localparam int unsigned         MS_PER_SEC_W = 10;
  localparam logic [RATE_W-1:0]   RATE_MAX     = 20'hFFFFF;
  localparam logic [FRAMES_W-1:0] FRAMES_MAX   = 11'h7FF;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic drop_head;
    logic push;
    logic div_start;
    logic div_step;
    logic load_out;
  } swfr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic expired;
    logic div_done;
  } swfr_sts_t;

endpackage

// File: rtl/swfr_if.sv
// ----------------------------------------------------------------------------
// swfr channel interfaces
// Valid/ready channels for frame events, rate results and window writes.
// ----------------------------------------------------------------------------
interface swfr_in_if;
  import swfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick_ms;
  logic              clear;

  modport source (output valid, output tick_ms, output clear, input ready);
  modport sink   (input valid, input tick_ms, input clear, output ready);
endinterface

interface swfr_out_if;
  import swfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [RATE_W-1:0]   rate;
  logic [FRAMES_W-1:0] frames_in_window;

  modport source (output valid, output rate, output frames_in_window, input ready);
  modport sink   (input valid, input rate, input frames_in_window, output ready);
endinterface

interface swfr_cfg_if;
  import swfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [WINDOW_W-1:0] window_ms;

  modport source (output valid, output window_ms, input ready);
  modport sink   (input valid, input window_ms, output ready);
endinterface

// File: rtl/swfr_ram.sv
// ----------------------------------------------------------------------------
// swfr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/swfr_ctrl.sv
// ----------------------------------------------------------------------------
// swfr_ctrl
// Sequencer: push, eviction walk, serial divide and result hand-off.
// ----------------------------------------------------------------------------
module swfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  swfr_pkg::swfr_sts_t sts,
  output swfr_pkg::swfr_cmd_t cmd
);
  import swfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DROP,
    S_PUSH,
    S_EV_RD,
    S_EV_CHK,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.full) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_DROP;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = S_EV_RD;
        end
      end
      S_DROP: begin
        cmd.drop_head = 1'b1;
        state_nxt     = S_PUSH;
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_EV_RD;
      end
      S_EV_RD: begin
        if (sts.empty) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (sts.expired) begin
          cmd.drop_head = 1'b1;
          state_nxt     = S_EV_RD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/swfr_dp.sv
// ----------------------------------------------------------------------------
// swfr_dp
// Datapath: stamp and gap rings, ring pointers, gap sum, window register,
// restoring divider and result registers.
// ----------------------------------------------------------------------------
module swfr_dp #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [swfr_pkg::TICK_W-1:0]   tick_ms,
  input  logic                          clear,
  input  logic                          cfg_we,
  input  logic [swfr_pkg::WINDOW_W-1:0] cfg_window_ms,
  input  swfr_pkg::swfr_cmd_t           cmd,
  output swfr_pkg::swfr_sts_t           sts,
  output logic [swfr_pkg::RATE_W-1:0]   rate,
  output logic [swfr_pkg::FRAMES_W-1:0] frames_in_window
);
  import swfr_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SB = STAMP_BITS;
  localparam int unsigned NW = CW + MS_PER_SEC_W;
  localparam int unsigned DW = $clog2(NW + 1);
  localparam int unsigned QW = (NW > RATE_W) ? NW : RATE_W;
  localparam int unsigned FW = (CW > FRAMES_W) ? CW : FRAMES_W;

  logic [AW-1:0]       head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SB-1:0]       sum_r, sum_nxt;
  logic [SB-1:0]       prev_r, prev_nxt;
  logic                have_prev_r, have_prev_nxt;
  logic [WINDOW_W-1:0] window_r;
  logic [SB-1:0]       now_r, gap_r, thr_r;
  logic [NW-1:0]       num_r;
  logic [SB-1:0]       rem_r;
  logic [DW-1:0]       dcnt_r;
  logic [RATE_W-1:0]   rate_r;
  logic [FRAMES_W-1:0] frames_r;

  logic [SB-1:0]       now_in, win_ext;
  logic [SB-1:0]       stamp_rd, gap_rd;
  logic [SB:0]         trial;
  logic                q_bit;
  logic [QW-1:0]       q_wide;
  logic [FW-1:0]       c_wide;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == AW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign now_in  = SB'(tick_ms);
  assign win_ext = SB'(window_r);

  swfr_ram #(.WIDTH(SB), .DEPTH(RING_DEPTH)) u_stamp_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail_r),
    .wr_data (now_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (head_r),
    .rd_data (stamp_rd)
  );

  swfr_ram #(.WIDTH(SB), .DEPTH(RING_DEPTH)) u_gap_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail_r),
    .wr_data (gap_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (head_r),
    .rd_data (gap_rd)
  );

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    if (cmd.accept && clear) begin
      head_nxt      = '0;
      tail_nxt      = '0;
      count_nxt     = '0;
      sum_nxt       = '0;
      prev_nxt      = '0;
      have_prev_nxt = 1'b0;
    end
    if (cmd.drop_head) begin
      sum_nxt   = sum_r - gap_rd;
      head_nxt  = next_slot(head_r);
      count_nxt = count_r - 1'b1;
    end
    if (cmd.push) begin
      tail_nxt      = next_slot(tail_r);
      count_nxt     = count_r + 1'b1;
      sum_nxt       = sum_r + gap_r;
      prev_nxt      = now_r;
      have_prev_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      window_r    <= WINDOW_RESET;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      if (cfg_we) begin
        window_r <= cfg_window_ms;
      end
    end
  end

  // transaction capture: gap and saturating window threshold
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r <= now_in;
      gap_r <= (have_prev_r && !clear) ? now_in - prev_r : '0;
      thr_r <= (now_in >= win_ext) ? now_in - win_ext : '0;
    end
  end

  // restoring divider, quotient shifts into the numerator register
  assign trial = {rem_r, num_r[NW-1]};
  assign q_bit = (trial >= {1'b0, sum_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= DW'(NW);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r <= NW'(count_r) * NW'(MS_PER_SEC);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? SB'(trial - {1'b0, sum_r}) : trial[SB-1:0];
      num_r <= {num_r[NW-2:0], q_bit};
    end
  end

  assign q_wide = QW'(num_r);
  assign c_wide = FW'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (sum_r == '0) begin
        rate_r <= '0;
      end else begin
        rate_r <= (q_wide > QW'(RATE_MAX)) ? RATE_MAX : q_wide[RATE_W-1:0];
      end
      frames_r <= (c_wide > FW'(FRAMES_MAX)) ? FRAMES_MAX : c_wide[FRAMES_W-1:0];
    end
  end

  assign sts.full     = (count_r == CW'(RING_DEPTH));
  assign sts.empty    = (count_r == '0);
  assign sts.expired  = (stamp_rd <= thr_r);
  assign sts.div_done = (dcnt_r == DW'(1));

  assign rate             = rate_r;
  assign frames_in_window = frames_r;

endmodule

// File: rtl/sliding_window_frame_rate_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_frame_rate_unit
// Sliding window frame rate meter: frame count and frames per second over a
// programmable millisecond window.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one frame event per transaction (tick_ms, clear);
// out_ch returns one result per event (rate, frames_in_window); cfg_ch writes
// window_ms and is always ready.
// One event is processed at a time. After acceptance the unit pushes the
// stamp into the ring (dropping the head first when the ring is full),
// walks the head of the ring, dropping each expired entry, until it finds
// an unexpired entry or the ring drains, then runs a restoring divider of
// clog2(RING_DEPTH+1)+10 steps (21 at the default depth). The eviction walk
// through the ring RAM read port and the divider set the processing time.
// in_ch.ready rises the cycle after the result is loaded into the output
// register, so a new event is taken only once the last one is through;
// while the receiver stalls the next event is still accepted and processed,
// then held until the output register is free.
// Reset clears pointers, count, gap sum and history and sets window_ms to
// 1000; ring contents are not cleared, no sweep is needed.
// ----------------------------------------------------------------------------
module sliding_window_frame_rate_unit #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  swfr_in_if.sink    in_ch,
  swfr_out_if.source out_ch,
  swfr_cfg_if.sink   cfg_ch
);
  import swfr_pkg::*;

  swfr_cmd_t cmd;
  swfr_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  swfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swfr_dp #(
    .RING_DEPTH (RING_DEPTH),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .tick_ms          (in_ch.tick_ms),
    .clear            (in_ch.clear),
    .cfg_we           (cfg_ch.valid),
    .cfg_window_ms    (cfg_ch.window_ms),
    .cmd              (cmd),
    .sts              (sts),
    .rate             (out_ch.rate),
    .frames_in_window (out_ch.frames_in_window)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an event is in flight");

  a_no_drop_and_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.drop_head))
    else $error("ring push and drop in the same cycle");

  a_empty_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frames_in_window == '0) |-> out_ch.rate == '0)
    else $error("non-zero rate with an empty window");

  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> 32'(out_ch.frames_in_window) <= 32'(RING_DEPTH))
    else $error("frame count beyond ring depth");

endmodule

// File: test/sliding_window_frame_rate_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_frame_rate_unit_tb
// Self-checking bench: frame events go in through a backlog-fed driver, a
// transaction-level copy of the rate meter predicts each reading, and a monitor
// compares every result against the oldest predicted reading.
// ----------------------------------------------------------------------------
module sliding_window_frame_rate_unit_tb;
  import swfr_pkg::*;

  localparam int unsigned RING_SLOTS    = 1024;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_AT       = 700;
  localparam int unsigned HOLD_CYCLES   = 800;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic              clear;
  } frame_evt_t;

  typedef struct packed {
    logic [RATE_W-1:0]   rate;
    logic [FRAMES_W-1:0] frames;
  } rate_reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swfr_in_if  in_ch ();
  swfr_out_if out_ch ();
  swfr_cfg_if cfg_ch ();

  sliding_window_frame_rate_unit #(
    .RING_DEPTH(RING_SLOTS),
    .STAMP_BITS(TICK_W)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // meter state as the block should hold it
  logic [TICK_W-1:0]   stamp_mem [RING_SLOTS];
  logic [TICK_W-1:0]   gap_mem   [RING_SLOTS];
  int unsigned         head_ptr   = 0;
  int unsigned         tail_ptr   = 0;
  int unsigned         held       = 0;
  logic [TICK_W-1:0]   gap_total  = '0;
  logic [TICK_W-1:0]   last_stamp = '0;
  bit                  seen_stamp = 1'b0;
  logic [WINDOW_W-1:0] window_cur = WINDOW_RESET;

  frame_evt_t    frame_backlog [$];
  rate_reading_t pending_readings [$];

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count  = 0;
  int unsigned fault_count    = 0;
  int unsigned cycle_count    = 0;
  bit          in_taken       = 1'b0;
  bit          steady         = 1'b0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;

  function automatic void retire_oldest();
    gap_total = gap_total - gap_mem[head_ptr];
    head_ptr  = (head_ptr + 1) % RING_SLOTS;
    held--;
  endfunction

  function automatic rate_reading_t meter_frame(logic [TICK_W-1:0] now, logic clr);
    logic [TICK_W-1:0] gap;
    logic [TICK_W-1:0] limit_stamp;
    longint unsigned   quotient;
    rate_reading_t     r;
    if (clr) begin
      head_ptr   = 0;
      tail_ptr   = 0;
      held       = 0;
      gap_total  = '0;
      last_stamp = '0;
      seen_stamp = 1'b0;
    end
    gap = seen_stamp ? now - last_stamp : '0;
    if (held >= RING_SLOTS) retire_oldest();
    stamp_mem[tail_ptr] = now;
    gap_mem[tail_ptr]   = gap;
    tail_ptr   = (tail_ptr + 1) % RING_SLOTS;
    held++;
    gap_total  = gap_total + gap;
    last_stamp = now;
    seen_stamp = 1'b1;
    // threshold clamps at zero for early stamps
    limit_stamp = (now >= TICK_W'(window_cur)) ? now - TICK_W'(window_cur) : '0;
    while (held > 0 && stamp_mem[head_ptr] <= limit_stamp) retire_oldest();
    quotient = 0;
    if (gap_total != '0) begin
      quotient = (64'(MS_PER_SEC) * 64'(held)) / 64'(gap_total);
      if (quotient > 64'(RATE_MAX)) quotient = 64'(RATE_MAX);
    end
    r.rate   = quotient[RATE_W-1:0];
    r.frames = (held > 32'(FRAMES_MAX)) ? FRAMES_MAX : FRAMES_W'(held);
    return r;
  endfunction

  // frame driver
  always @(negedge clk) begin : feed
    frame_evt_t nxt;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.tick_ms <= '0;
      in_ch.clear   <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (frame_backlog.size() > 0 && (steady || $urandom_range(99) >= 25)) begin
        nxt = frame_backlog.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.tick_ms <= nxt.tick;
        in_ch.clear   <= nxt.clear;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the unit up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && checked_count >= HOLD_AT) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || $urandom_range(99) >= 25;
    end
  end

  // monitor: transactions on all three channels
  always @(posedge clk) begin : watch
    rate_reading_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_readings.size() == 0) begin
          $display("%0t unexpected result: rate %0d frames_in_window %0d",
                   $time, out_ch.rate, out_ch.frames_in_window);
          fault_count++;
        end else begin
          want = pending_readings.pop_front();
          if (out_ch.rate !== want.rate) begin
            $display("%0t rate mismatch: expected %0d actual %0d",
                     $time, want.rate, out_ch.rate);
            fault_count++;
          end
          if (out_ch.frames_in_window !== want.frames) begin
            $display("%0t frames_in_window mismatch: expected %0d actual %0d",
                     $time, want.frames, out_ch.frames_in_window);
            fault_count++;
          end
          checked_count++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_readings.push_back(meter_frame(in_ch.tick_ms, in_ch.clear));
        accepted_count++;
        in_taken = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) window_cur = cfg_ch.window_ms;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic void queue_frame(logic [TICK_W-1:0] t, logic c);
    frame_backlog.push_back('{tick: t, clear: c});
    queued_count++;
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (accepted_count != queued_count || checked_count != accepted_count);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(logic [WINDOW_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.window_ms <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly rising stamps at window-scaled gaps, with noise, rewinds and clears
  task automatic queue_burst(int unsigned n, int unsigned win);
    logic [TICK_W-1:0] tick;
    int unsigned       pick;
    tick = $urandom;
    queue_frame(tick, 1'($urandom_range(1)));
    repeat (n - 1) begin
      pick = $urandom_range(99);
      if (pick < 8) tick = $urandom;
      else if (pick < 13) tick = tick - $urandom_range(win, 1);
      else tick = tick + $urandom_range(win / 6 + 2, 0);
      queue_frame(tick, $urandom_range(99) < 3);
    end
  endtask

  initial begin : run
    logic [TICK_W-1:0] tick;
    int unsigned       win;
    cfg_ch.valid     = 1'b0;
    cfg_ch.window_ms = WINDOW_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default window: first frame, early stamps, wrap, rewind, clear
    queue_frame(32'd0, 1'b0);
    queue_frame(32'd5, 1'b0);
    queue_frame(32'd10, 1'b0);
    queue_frame(32'd999, 1'b0);
    queue_frame(32'd1999, 1'b0);
    queue_frame(32'hFFFF_FFFF, 1'b0);
    queue_frame(32'hFFFF_FFF0, 1'b1);
    queue_frame(32'hFFFF_FFF0, 1'b0);
    queue_frame(32'd100, 1'b0);
    queue_frame(32'd50, 1'b0);
    queue_frame(32'h8000_0000, 1'b0);
    queue_frame(32'h7FFF_FFFF, 1'b0);
    queue_frame(32'd3, 1'b1);
    queue_frame(32'd4, 1'b0);
    settle();

    // zero window drops everything
    write_window('0);
    queue_frame(32'd20, 1'b0);
    queue_frame(32'd20, 1'b1);
    queue_frame(32'd0, 1'b0);
    settle();

    write_window('1);
    queue_frame(32'd0, 1'b1);
    queue_frame(32'd1000, 1'b0);
    queue_frame(32'd65534, 1'b0);
    queue_frame(32'd65535, 1'b0);
    queue_frame(32'd65536, 1'b0);
    queue_frame(32'd200000, 1'b0);
    settle();

    write_window(16'd1);
    queue_frame(32'd7, 1'b0);
    queue_frame(32'd8, 1'b0);
    queue_frame(32'd8, 1'b0);
    queue_frame(32'd9, 1'b0);
    settle();

    // overfill the ring with dense stamps, then one far stamp evicts all older ones
    write_window(16'd60000);
    steady = 1'b1;
    tick = 32'd100000;
    queue_frame(tick, 1'b1);
    repeat (1100) begin
      tick = tick + 32'($urandom_range(9) == 0);
      queue_frame(tick, 1'b0);
    end
    queue_frame(tick + 32'd100000, 1'b0);
    settle();
    steady = 1'b0;

    for (int i = 0; i < 5; i++) begin
      case (i)
        0:       win = 50;
        1:       win = 400;
        2:       win = 2500;
        3:       win = $urandom_range(65535, 1);
        default: win = WINDOW_RESET;
      endcase
      write_window(WINDOW_W'(win));
      queue_burst(100, win);
      settle();
    end

    if (fault_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
rtl/swfr_pkg.sv
rtl/swfr_if.sv
rtl/swfr_ram.sv
rtl/swfr_ctrl.sv
rtl/swfr_dp.sv
rtl/sliding_window_frame_rate_unit.sv
test/sliding_window_frame_rate_unit_tb.sv
